// ===== hw/rtl/spa_pkg.sv =====
// Shared command codes and field widths for the sparse polynomial adder.
`default_nettype none
package spa_pkg;
    localparam int EXP_W  = 6;
    localparam int COEF_W = 16;
    localparam int OUT_W  = 32;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EMIT = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/spa_sat_add.sv =====
// Saturating adder shared by every term accumulation.
`default_nettype none
module spa_sat_add #(
    parameter int SUM_WIDTH = 32
) (
    input  wire logic signed [SUM_WIDTH-1:0]            i_acc,
    input  wire logic signed [spa_pkg::COEF_W-1:0]      i_addend,
    output logic signed [SUM_WIDTH-1:0]                 o_sum
);
    localparam logic [SUM_WIDTH-1:0] SAT_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SAT_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [SUM_WIDTH:0] full;

    assign full = (SUM_WIDTH+1)'(i_acc) + (SUM_WIDTH+1)'(i_addend);

    always_comb begin
        // top two bits disagree: result left the signed range
        if (full[SUM_WIDTH] != full[SUM_WIDTH-1]) begin
            o_sum = full[SUM_WIDTH] ? SAT_MIN : SAT_MAX;
        end else begin
            o_sum = full[SUM_WIDTH-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/spa_table.sv =====
// Coefficient table: one write port, one registered read port.
`default_nettype none
module spa_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [DW-1:0]      o_rdata
);
    logic [DW-1:0] mem [DEPTH];

    // read returns the old word when read and write hit the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sparse_polynomial_adder_core.sv =====
// An add reads its entry when accepted and writes the saturating sum back in ST_ADD, busy high.
// An emit scans one table entry per cycle from the top index down, then passes ST_DRAIN and
// ST_FINAL; results are strobed during the scan, the last one in the cycle that busy drops.
// A command is accepted only in ST_IDLE, so each add or emit finishes before the next is taken.
// Results cannot be stalled.
// Reset: synchronous; a clearing pass zeroes the table, top index down, while busy.
`default_nettype none
module sparse_polynomial_adder_core #(
    parameter int NUM_EXPONENTS = 64,
    parameter int SUM_WIDTH     = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_command,
    input  wire logic [spa_pkg::EXP_W-1:0]          i_exponent,
    input  wire logic signed [spa_pkg::COEF_W-1:0]  i_coefficient,
    output logic                                    o_strobe,
    output logic [spa_pkg::EXP_W-1:0]               o_out_exponent,
    output logic signed [spa_pkg::OUT_W-1:0]        o_out_coefficient,
    output logic                                    o_has_term,
    output logic                                    o_last
);
    localparam int AW = $clog2(NUM_EXPONENTS);
    localparam int CW = ((AW > spa_pkg::EXP_W) ? AW : spa_pkg::EXP_W) + 1;
    localparam logic [AW-1:0] TOP_IDX = AW'(NUM_EXPONENTS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [AW-1:0]                   r_idx, n_idx;
    logic                            r_in_range, n_in_range;
    logic signed [spa_pkg::COEF_W-1:0] r_coef, n_coef;
    logic                            r_rd_vld, n_rd_vld;
    logic [AW-1:0]                   r_rd_idx, n_rd_idx;
    logic                            r_pend_vld, n_pend_vld;
    logic [spa_pkg::EXP_W-1:0]       r_pend_exp, n_pend_exp;
    logic signed [spa_pkg::OUT_W-1:0] r_pend_coef, n_pend_coef;
    logic                            r_strobe, n_strobe;
    logic [spa_pkg::EXP_W-1:0]       r_out_exp, n_out_exp;
    logic signed [spa_pkg::OUT_W-1:0] r_out_coef, n_out_coef;
    logic                            r_has_term, n_has_term;
    logic                            r_last, n_last;

    logic [CW-1:0]                   in_exp_wide;
    logic [AW-1:0]                   in_idx;
    logic                            in_range;
    logic                            accept;
    logic                            tbl_we;
    logic [AW-1:0]                   tbl_raddr;
    logic [SUM_WIDTH-1:0]            tbl_wdata;
    logic signed [SUM_WIDTH-1:0]     tbl_rdata;
    logic signed [SUM_WIDTH-1:0]     sum;

    assign in_exp_wide = CW'(i_exponent);
    assign in_idx      = in_exp_wide[AW-1:0];
    assign in_range    = in_exp_wide < CW'(NUM_EXPONENTS);
    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);

    assign tbl_raddr = (r_state == ST_IDLE) ? in_idx : r_idx;
    assign tbl_we    = (r_state == ST_CLEAR) || (r_state == ST_SCAN)
                    || ((r_state == ST_ADD) && r_in_range);
    assign tbl_wdata = (r_state == ST_ADD) ? sum : '0;

    spa_table #(
        .DEPTH (NUM_EXPONENTS),
        .AW    (AW),
        .DW    (SUM_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_idx),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    spa_sat_add #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_sat_add (
        .i_acc    (tbl_rdata),
        .i_addend (r_coef),
        .o_sum    (sum)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_in_range  = r_in_range;
        n_coef      = r_coef;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_idx;
        n_pend_vld  = r_pend_vld;
        n_pend_exp  = r_pend_exp;
        n_pend_coef = r_pend_coef;
        n_strobe    = 1'b0;
        n_out_exp   = r_out_exp;
        n_out_coef  = r_out_coef;
        n_has_term  = r_has_term;
        n_last      = r_last;

        // scan read data from the previous cycle; a nonzero entry pushes out the held one
        if (r_rd_vld && (tbl_rdata != '0)) begin
            if (r_pend_vld) begin
                n_strobe   = 1'b1;
                n_out_exp  = r_pend_exp;
                n_out_coef = r_pend_coef;
                n_has_term = 1'b1;
                n_last     = 1'b0;
            end
            n_pend_vld  = 1'b1;
            n_pend_exp  = spa_pkg::EXP_W'(r_rd_idx);
            n_pend_coef = spa_pkg::OUT_W'(tbl_rdata);
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx - AW'(1);
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == spa_pkg::CMD_EMIT) begin
                        n_idx      = TOP_IDX;
                        n_pend_vld = 1'b0;
                        n_state    = ST_SCAN;
                    end else begin
                        n_idx      = in_idx;
                        n_in_range = in_range;
                        n_coef     = i_coefficient;
                        n_state    = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                n_idx    = r_idx - AW'(1);
                if (r_idx == '0) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                if (r_pend_vld) begin
                    n_out_exp  = r_pend_exp;
                    n_out_coef = r_pend_coef;
                    n_has_term = 1'b1;
                end else begin
                    n_out_exp  = '0;
                    n_out_coef = '0;
                    n_has_term = 1'b0;
                end
                n_pend_vld = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = TOP_IDX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= TOP_IDX;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_range  <= n_in_range;
        r_coef      <= n_coef;
        r_rd_idx    <= n_rd_idx;
        r_pend_exp  <= n_pend_exp;
        r_pend_coef <= n_pend_coef;
        r_out_exp   <= n_out_exp;
        r_out_coef  <= n_out_coef;
        r_has_term  <= n_has_term;
        r_last      <= n_last;
    end

    assign o_strobe          = r_strobe;
    assign o_out_exponent    = r_out_exp;
    assign o_out_coefficient = r_out_coef;
    assign o_has_term        = r_has_term;
    assign o_last            = r_last;
endmodule
`default_nettype wire

// ===== hw/rtl/spa_checker.sv =====
// Port-level checks for the sparse polynomial adder, bound to the top level.
`default_nettype none
module spa_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               i_command,
    input wire logic                               o_strobe,
    input wire logic [spa_pkg::EXP_W-1:0]          o_out_exponent,
    input wire logic signed [spa_pkg::OUT_W-1:0]   o_out_coefficient,
    input wire logic                               o_has_term,
    input wire logic                               o_last
);
    // every word out belongs to an emit that kept the block busy
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a preceding busy emit");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_term) |-> (o_last && o_out_exponent == '0
                                       && o_out_coefficient == '0))
        else $error("empty-sum word malformed");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("word after the last word of an emit");

    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == spa_pkg::CMD_ADD) |=> !o_strobe)
        else $error("add command produced a word");
endmodule

bind sparse_polynomial_adder_core spa_checker u_spa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_command         (i_command),
    .o_strobe          (o_strobe),
    .o_out_exponent    (o_out_exponent),
    .o_out_coefficient (o_out_coefficient),
    .o_has_term        (o_has_term),
    .o_last            (o_last)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the sparse polynomial adder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_W      = spa_pkg::EXP_W;
    localparam int COEF_W     = spa_pkg::COEF_W;
    localparam int OUT_W      = spa_pkg::OUT_W;
    localparam int NEXP       = 64;
    localparam int SUMW       = 32;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [EXP_W-1:0] exponent;
        logic [OUT_W-1:0] coefficient;
        logic             has_term;
        logic             last;
    } t_sum_term;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_command;
    logic [EXP_W-1:0]         i_exponent;
    logic signed [COEF_W-1:0] i_coefficient;
    logic                     o_strobe;
    logic [EXP_W-1:0]         o_out_exponent;
    logic signed [OUT_W-1:0]  o_out_coefficient;
    logic                     o_has_term;
    logic                     o_last;

    // model state: one saturating sum per exponent
    longint    term_sum [NEXP];
    t_sum_term pending_terms [$];

    int n_words;
    int n_emits;
    int n_empty;
    int n_full_scans;
    int n_saturated;
    int n_checked;
    int n_mismatch;
    int idle_cycles;
    int burst_left;
    bit steady;

    sparse_polynomial_adder_core #(
        .NUM_EXPONENTS(NEXP),
        .SUM_WIDTH    (SUMW)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_exponent       (i_exponent),
        .i_coefficient    (i_coefficient),
        .o_strobe         (o_strobe),
        .o_out_exponent   (o_out_exponent),
        .o_out_coefficient(o_out_coefficient),
        .o_has_term       (o_has_term),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat_accumulate(input longint acc, input longint c);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SUMW - 1)) - 1;
        lo = -hi - 1;
        if (c > 0 && acc > hi - c) return hi;
        if (c < 0 && acc < lo - c) return lo;
        return acc + c;
    endfunction

    // Update the model for one accepted word; an emit queues the expected terms.
    task automatic apply_word(input logic cmd, input logic [EXP_W-1:0] e,
                              input logic signed [COEF_W-1:0] c);
        t_sum_term t;
        int        i;
        int        lowest;
        int        n;
        longint    hi;
        hi = (longint'(1) <<< (SUMW - 1)) - 1;
        if (cmd == spa_pkg::CMD_ADD) begin
            if (e < NEXP) term_sum[e] = sat_accumulate(term_sum[e], longint'(c));
        end else begin
            n_emits++;
            lowest = -1;
            n = 0;
            for (i = NEXP - 1; i >= 0; i--) begin
                if (term_sum[i] != 0) begin
                    lowest = i;
                    n++;
                end
            end
            for (i = NEXP - 1; i >= 0; i--) begin
                if (term_sum[i] != 0) begin
                    t.exponent    = EXP_W'(i);
                    t.coefficient = OUT_W'(term_sum[i]);
                    t.has_term    = 1'b1;
                    t.last        = (i == lowest);
                    pending_terms.push_back(t);
                    if (term_sum[i] == hi || term_sum[i] == -hi - 1) n_saturated++;
                end
            end
            if (n == 0) begin
                t = '0;
                t.last = 1'b1;
                pending_terms.push_back(t);
                n_empty++;
            end
            if (n == NEXP) n_full_scans++;
            for (i = 0; i < NEXP; i++) term_sum[i] = 0;
        end
    endtask

    // Present one word and hold it until accepted; then maybe open a gap.
    task automatic send_word(input logic cmd, input logic [EXP_W-1:0] e,
                             input logic signed [COEF_W-1:0] c);
        int gap;
        start         <= 1'b1;
        i_command     <= cmd;
        i_exponent    <= e;
        i_coefficient <= c;
        do @(posedge i_clk); while (busy);
        apply_word(cmd, e, c);
        n_words++;
        if (!steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                case ($urandom_range(0, 19))
                    0:       gap = $urandom_range(30, 90);
                    1, 2, 3: gap = $urandom_range(5, 20);
                    default: gap = $urandom_range(1, 4);
                endcase
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_terms.size() != 0);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Result checker: every strobe must match the oldest expected term.
    always @(posedge i_clk) begin : check_results
        t_sum_term want;
        if (i_rst_n && o_strobe) begin
            if (pending_terms.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("tb: unexpected result e=%0d c=%0d has=%0b last=%0b",
                             o_out_exponent, o_out_coefficient, o_has_term, o_last);
            end else begin
                want = pending_terms.pop_front();
                n_checked++;
                if (o_out_exponent !== want.exponent || o_out_coefficient !== want.coefficient
                    || o_has_term !== want.has_term || o_last !== want.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"tb: mismatch at %0t: want e=%0d c=%0d has=%0b last=%0b,",
                                  " got e=%0d c=%0d has=%0b last=%0b"}, $realtime,
                                 want.exponent, $signed(want.coefficient), want.has_term,
                                 want.last, o_out_exponent, o_out_coefficient, o_has_term,
                                 o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else                              idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

    task automatic test_empty_sum();
        send_word(spa_pkg::CMD_EMIT, 6'd0, 16'sd0);
    endtask

    // Field extremes, cancellation to zero, a zero coefficient, then emit twice.
    task automatic test_extreme_terms();
        send_word(spa_pkg::CMD_ADD, 6'd63, 16'sh7FFF);
        send_word(spa_pkg::CMD_ADD, 6'd0, 16'sh8000);
        send_word(spa_pkg::CMD_ADD, 6'd31, 16'sd1);
        send_word(spa_pkg::CMD_ADD, 6'd32, -16'sd1);
        send_word(spa_pkg::CMD_ADD, 6'd5, 16'sd7);
        send_word(spa_pkg::CMD_ADD, 6'd5, -16'sd7);
        send_word(spa_pkg::CMD_ADD, 6'd10, 16'sd0);
        send_word(spa_pkg::CMD_ADD, 6'd63, 16'sd1);
        send_word(spa_pkg::CMD_ADD, 6'd21, 16'sh5555);
        send_word(spa_pkg::CMD_ADD, 6'd42, 16'shAAAA);
        send_word(spa_pkg::CMD_EMIT, 6'd63, 16'shFFFF);
        send_word(spa_pkg::CMD_EMIT, 6'd0, 16'sd0);
    endtask

    // Same exponent on consecutive words: each read must see the previous write back.
    task automatic test_back_to_back_adds();
        steady = 1'b1;
        send_word(spa_pkg::CMD_ADD, 6'd7, 16'sd100);
        send_word(spa_pkg::CMD_ADD, 6'd7, 16'sd100);
        send_word(spa_pkg::CMD_ADD, 6'd7, 16'sd100);
        send_word(spa_pkg::CMD_ADD, 6'd8, -16'sd50);
        send_word(spa_pkg::CMD_ADD, 6'd7, -16'sd1);
        send_word(spa_pkg::CMD_EMIT, 6'd0, 16'sd0);
        steady = 1'b0;
    endtask

    // Grow sums well past the coefficient range in both directions, then step back.
    task automatic test_large_sums();
        steady = 1'b1;
        repeat (6) send_word(spa_pkg::CMD_ADD, 6'd40, 16'sh7FFF);
        send_word(spa_pkg::CMD_ADD, 6'd40, -16'sd1);
        send_word(spa_pkg::CMD_ADD, 6'd40, 16'sd5);
        repeat (6) send_word(spa_pkg::CMD_ADD, 6'd41, 16'sh8000);
        send_word(spa_pkg::CMD_ADD, 6'd41, 16'sd1);
        send_word(spa_pkg::CMD_ADD, 6'd42, -16'sd3);
        send_word(spa_pkg::CMD_EMIT, 6'd0, 16'sd0);
        steady = 1'b0;
    endtask

    task automatic test_random(input int n_target);
        int                       first;
        int                       mode;
        int                       k;
        int                       lo_e;
        int                       hi_e;
        logic [EXP_W-1:0]         e;
        logic signed [COEF_W-1:0] c;
        logic [EXP_W-1:0]         undo_e [$];
        logic signed [COEF_W-1:0] undo_c [$];
        first = n_words;
        while (n_words - first < n_target) begin
            mode = $urandom_range(0, 99);
            steady = ($urandom_range(0, 4) == 0);
            if (mode < 3 && n_full_scans < 2) begin
                // every exponent nonzero: longest emit run
                for (k = 0; k < NEXP; k++) begin
                    do c = rand_coef(); while (c == 0);
                    send_word(spa_pkg::CMD_ADD, EXP_W'(k), c);
                end
                send_word(spa_pkg::CMD_EMIT, EXP_W'($urandom), COEF_W'($urandom));
            end else if (mode < 12) begin
                repeat ($urandom_range(0, 3))
                    send_word(spa_pkg::CMD_ADD, EXP_W'($urandom), 16'sd0);
                send_word(spa_pkg::CMD_EMIT, EXP_W'($urandom), COEF_W'($urandom));
            end else begin
                if (mode < 16) drain_results();
                lo_e = $urandom_range(0, NEXP - 1);
                hi_e = ($urandom_range(0, 1) == 0) ? $urandom_range(lo_e, lo_e + 3)
                                                   : $urandom_range(lo_e, NEXP - 1);
                if (hi_e > NEXP - 1) hi_e = NEXP - 1;
                // a few operand polynomials over a shared exponent window
                repeat ($urandom_range(1, 3)) begin
                    repeat ($urandom_range(1, 8)) begin
                        e = EXP_W'($urandom_range(lo_e, hi_e));
                        c = rand_coef();
                        send_word(spa_pkg::CMD_ADD, e, c);
                        if (c != 16'sh8000 && $urandom_range(0, 4) == 0) begin
                            undo_e.push_back(e);
                            undo_c.push_back(c);
                        end
                    end
                end
                while (undo_e.size() != 0)
                    send_word(spa_pkg::CMD_ADD, undo_e.pop_front(), -undo_c.pop_front());
                send_word(spa_pkg::CMD_EMIT, EXP_W'($urandom), COEF_W'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NEXP; i++) term_sum[i] = 0;
        n_words       = 0;
        n_emits       = 0;
        n_empty       = 0;
        n_full_scans  = 0;
        n_saturated   = 0;
        n_checked     = 0;
        n_mismatch    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        steady        = 1'b0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= spa_pkg::CMD_ADD;
        i_exponent    <= '0;
        i_coefficient <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_sum();
        test_extreme_terms();
        test_back_to_back_adds();
        drain_results();
        test_large_sums();
        test_random(390);

        drain_results();
        repeat (NEXP + 8) @(posedge i_clk);
        if (pending_terms.size() != 0) begin
            n_mismatch++;
            $display("tb: %0d expected results never arrived", pending_terms.size());
        end
        $display("tb: %0d words sent, %0d emits, %0d results checked, %0d mismatches",
                 n_words, n_emits, n_checked, n_mismatch);
        $display("tb: covered %0d empty sums, %0d full-table scans, %0d saturated sums",
                 n_empty, n_full_scans, n_saturated);
        if (n_mismatch == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/spa_pkg.sv
hw/rtl/spa_sat_add.sv
hw/rtl/spa_table.sv
hw/rtl/sparse_polynomial_adder_core.sv
hw/rtl/spa_checker.sv
bench/tb.sv
